[design/cpts_pkg.sv]
// Shared types, command codes and constants of the counter priority task scheduler.
`default_nettype none

package cpts_pkg;

  // Table size default and limits on counts
  localparam int NUM_TASKS_DEF = 16;
  localparam logic [8:0] COUNT_MAX = 9'd511;

  // Command codes
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_INSTALL = 3'd1;
  localparam logic [2:0] CMD_REMOVE  = 3'd2;
  localparam logic [2:0] CMD_SLEEP   = 3'd3;
  localparam logic [2:0] CMD_BLOCK   = 3'd4;
  localparam logic [2:0] CMD_WAKE    = 3'd5;

  // Run state codes
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_SLEEP = 2'd1;
  localparam logic [1:0] ST_BLOCK = 2'd2;

  // One request on the input channel
  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  task_index;
    logic [7:0]  priority_req;
    logic [8:0]  initial_count;
    logic [31:0] wake_time;
    logic [31:0] now_time;
  } cpts_in_t;

  // One result on the output channel
  typedef struct packed {
    logic [3:0] current_task;
    logic       switched;
    logic       none_runnable;
    logic [8:0] current_count;
  } cpts_out_t;

  // One task table entry
  typedef struct packed {
    logic [1:0] run;
    logic [8:0] count;
    logic [7:0] prio;
  } cpts_entry_t;

  // Table access controls from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wake_we;
    logic pres_set;
    logic pres_clr;
  } cpts_tbl_ctl_t;

endpackage

`default_nettype wire

[design/counter_priority_task_scheduler.sv]
// Top level of the counter priority task scheduler: command sequencer over the task table.
// Install, remove and unknown commands go from lookup straight to the final read; a tick
// without reschedule and a wake first read and may rewrite one entry; sleep, block and a
// rescheduling tick also scan the table, plus a recharge pass if all runnable counts are zero.
// Throughput: one request at a time; each table pass reads one slot per cycle on one port.
// Reset: synchronous active-low rst_n clears present bits, running slot and control; no sweep.
`default_nettype none

module counter_priority_task_scheduler #(
  parameter int NUM_TASKS = cpts_pkg::NUM_TASKS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cpts_pkg::cpts_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cpts_pkg::cpts_out_t     out_data
);
  import cpts_pkg::*;

  localparam int IDX_W = $clog2(NUM_TASKS);
  localparam int CNT_W = $clog2(NUM_TASKS + 1);
  localparam logic [CNT_W-1:0] N_CNT  = CNT_W'(NUM_TASKS);
  localparam logic [IDX_W-1:0] LAST_I = IDX_W'(NUM_TASKS - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOOK   = 7'b0000010,
    S_CHK    = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_RECH   = 7'b0010000,
    S_FIN_RD = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  cpts_in_t          item_r, item_nxt;
  logic [IDX_W-1:0]  running_r, running_nxt;
  logic              sw_r, sw_nxt;
  logic              none_r, none_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  proc_r, proc_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [8:0]        best_cnt_r, best_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  cpts_out_t         out_data_r, out_data_nxt;

  cpts_tbl_ctl_t     ctl;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  cpts_entry_t       wr_entry;
  logic [31:0]       wake_wdata;
  cpts_entry_t       rd_entry;
  logic              rd_pres;
  logic [31:0]       rd_wake;

  logic              idx_ok;
  logic [IDX_W-1:0]  tidx;

  cpts_table #(
    .NUM_TASKS (NUM_TASKS)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_entry   (wr_entry),
    .wake_wdata (wake_wdata),
    .rd_entry   (rd_entry),
    .rd_pres    (rd_pres),
    .rd_wake    (rd_wake)
  );

  assign idx_ok = 32'(item_r.task_index) < NUM_TASKS;
  assign tidx   = IDX_W'(item_r.task_index);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequence one request through the table
  always_comb begin
    logic       wk;
    logic       cand;
    logic       better;
    logic [9:0] sum;
    logic [8:0] newc;

    state_nxt     = state_r;
    item_nxt      = item_r;
    running_nxt   = running_r;
    sw_nxt        = sw_r;
    none_nxt      = none_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    proc_nxt      = proc_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_cnt_nxt  = best_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    rd_addr       = running_r;
    wr_addr       = running_r;
    wr_entry      = rd_entry;
    wake_wdata    = item_r.wake_time;

    // Wake test and recharge value for the entry now on the read port
    wk     = rd_pres && (rd_entry.run == ST_SLEEP) && (item_r.now_time > rd_wake);
    sum    = {2'b00, rd_entry.count[8:1]} + {2'b00, rd_entry.prio};
    newc   = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[8:0];
    cand   = 1'b0;
    better = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          sw_nxt    = 1'b0;
          none_nxt  = 1'b0;
          state_nxt = S_LOOK;
        end
      end

      S_LOOK: begin
        state_nxt = S_FIN_RD;
        unique case (item_r.command) inside
          CMD_TICK, CMD_SLEEP, CMD_BLOCK: begin
            ctl.rd_en = 1'b1;
            rd_addr   = running_r;
            state_nxt = S_CHK;
          end
          CMD_INSTALL: begin
            if (idx_ok) begin
              ctl.wr_en    = 1'b1;
              ctl.pres_set = 1'b1;
              wr_addr      = tidx;
              wr_entry     = '{run: ST_RUN, count: item_r.initial_count,
                               prio: item_r.priority_req};
            end
          end
          CMD_REMOVE: begin
            if (idx_ok) begin
              ctl.pres_clr = 1'b1;
              wr_addr      = tidx;
            end
          end
          CMD_WAKE: begin
            if (idx_ok) begin
              ctl.rd_en = 1'b1;
              rd_addr   = tidx;
              state_nxt = S_CHK;
            end
          end
          default: begin
          end
        endcase
      end

      S_CHK: begin
        state_nxt = S_FIN_RD;
        cnt_nxt   = '0;
        found_nxt = 1'b0;
        unique case (item_r.command)
          CMD_TICK: begin
            if (rd_entry.count != 9'd0) begin
              ctl.wr_en      = 1'b1;
              wr_entry.count = rd_entry.count - 9'd1;
            end else begin
              sw_nxt    = 1'b1;
              state_nxt = S_SCAN;
            end
          end
          CMD_SLEEP: begin
            ctl.wr_en    = 1'b1;
            ctl.wake_we  = 1'b1;
            wr_entry.run = ST_SLEEP;
            sw_nxt       = 1'b1;
            state_nxt    = S_SCAN;
          end
          CMD_BLOCK: begin
            ctl.wr_en    = 1'b1;
            wr_entry.run = ST_BLOCK;
            sw_nxt       = 1'b1;
            state_nxt    = S_SCAN;
          end
          CMD_WAKE: begin
            wr_addr = tidx;
            if (rd_pres && (rd_entry.run == ST_SLEEP || rd_entry.run == ST_BLOCK)) begin
              ctl.wr_en    = 1'b1;
              wr_entry.run = ST_RUN;
            end
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        // Issue the next slot read
        if (cnt_r < N_CNT) begin
          ctl.rd_en = 1'b1;
          rd_addr   = cnt_r[IDX_W-1:0];
          proc_nxt  = cnt_r[IDX_W-1:0];
          pend_nxt  = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end
        // Wake expired sleepers and track the best runnable count
        if (pend_r) begin
          wr_addr = proc_r;
          if (wk) begin
            ctl.wr_en    = 1'b1;
            wr_entry.run = ST_RUN;
          end
          cand   = rd_pres && (wk || rd_entry.run == ST_RUN);
          better = cand && (!found_r || rd_entry.count > best_cnt_r);
          if (better) begin
            found_nxt    = 1'b1;
            best_idx_nxt = proc_r;
            best_cnt_nxt = rd_entry.count;
          end
          if (proc_r == LAST_I) begin
            cnt_nxt = '0;
            if (!found_nxt) begin
              running_nxt = '0;
              none_nxt    = 1'b1;
              state_nxt   = S_FIN_RD;
            end else if (best_cnt_nxt == 9'd0) begin
              found_nxt = 1'b0;
              state_nxt = S_RECH;
            end else begin
              running_nxt = best_idx_nxt;
              state_nxt   = S_FIN_RD;
            end
          end
        end
      end

      S_RECH: begin
        // Issue the next slot read
        if (cnt_r < N_CNT) begin
          ctl.rd_en = 1'b1;
          rd_addr   = cnt_r[IDX_W-1:0];
          proc_nxt  = cnt_r[IDX_W-1:0];
          pend_nxt  = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end
        // Recharge present slots and pick again on the new counts
        if (pend_r) begin
          wr_addr = proc_r;
          if (rd_pres) begin
            ctl.wr_en      = 1'b1;
            wr_entry.count = newc;
          end
          cand   = rd_pres && (rd_entry.run == ST_RUN);
          better = cand && (!found_r || newc > best_cnt_r);
          if (better) begin
            found_nxt    = 1'b1;
            best_idx_nxt = proc_r;
            best_cnt_nxt = newc;
          end
          if (proc_r == LAST_I) begin
            cnt_nxt     = '0;
            running_nxt = found_nxt ? best_idx_nxt : '0;
            state_nxt   = S_FIN_RD;
          end
        end
      end

      S_FIN_RD: begin
        ctl.rd_en = 1'b1;
        rd_addr   = running_r;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{current_task: 4'(running_r), switched: sw_r,
                            none_runnable: none_r, current_count: rd_entry.count};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      running_r   <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      sw_r        <= 1'b0;
      none_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      sw_r        <= sw_nxt;
      none_r      <= none_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    proc_r     <= proc_nxt;
    best_idx_r <= best_idx_nxt;
    best_cnt_r <= best_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

[design/cpts_table.sv]
// Task table memories: entry and wake time stores with per-slot present bits.
`default_nettype none

module cpts_table #(
  parameter int NUM_TASKS = cpts_pkg::NUM_TASKS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire cpts_pkg::cpts_tbl_ctl_t        ctl,
  input  wire logic [$clog2(NUM_TASKS)-1:0]   rd_addr,
  input  wire logic [$clog2(NUM_TASKS)-1:0]   wr_addr,
  input  wire cpts_pkg::cpts_entry_t          wr_entry,
  input  wire logic [31:0]                    wake_wdata,
  output cpts_pkg::cpts_entry_t               rd_entry,
  output logic                                rd_pres,
  output logic [31:0]                         rd_wake
);
  import cpts_pkg::*;

  cpts_entry_t             entry_mem [NUM_TASKS];
  logic [31:0]             wake_mem  [NUM_TASKS];
  logic [NUM_TASKS-1:0]    present_r;
  cpts_entry_t             rd_raw_r;
  logic                    rd_pres_r;
  logic [31:0]             rd_wake_r;

  // Write entry and wake time stores
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      entry_mem[wr_addr] <= wr_entry;
    end
    if (ctl.wake_we) begin
      wake_mem[wr_addr] <= wake_wdata;
    end
  end

  // Registered read, present bit sampled with the data
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_raw_r  <= entry_mem[rd_addr];
      rd_wake_r <= wake_mem[rd_addr];
      rd_pres_r <= present_r[rd_addr];
    end
  end

  // Track present slots; an absent slot reads as a cleared entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (ctl.pres_set) begin
      present_r[wr_addr] <= 1'b1;
    end else if (ctl.pres_clr) begin
      present_r[wr_addr] <= 1'b0;
    end
  end

  // Mask data of absent slots
  assign rd_entry = rd_pres_r ? rd_raw_r : '0;
  assign rd_pres  = rd_pres_r;
  assign rd_wake  = rd_wake_r;

endmodule

`default_nettype wire

[verif/cpts_checker.sv]
// Checker for the task scheduler: watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps

module cpts_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire cpts_pkg::cpts_in_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire cpts_pkg::cpts_out_t out_data,
  output int                       fail_count,
  output int                       pending,
  output int                       checked,
  output int                       resched_seen,
  output int                       idle_seen
);
  import cpts_pkg::*;

  localparam int NUM_SLOTS = NUM_TASKS_DEF;

  // Shadow copy of the task table
  logic        task_present [NUM_SLOTS];
  logic [1:0]  task_run     [NUM_SLOTS];
  logic [8:0]  task_count   [NUM_SLOTS];
  logic [7:0]  task_prio    [NUM_SLOTS];
  logic [31:0] task_wake    [NUM_SLOTS];
  logic [3:0]  run_slot;

  // Expected status for every request still in flight, oldest first
  cpts_out_t status_q [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 40)
      $display("%0t ns: %s differs, got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  // Present runnable slot with the largest count, lowest slot on a tie; -1 if none
  function automatic int pick_runnable();
    int best;
    int best_cnt;
    best = -1;
    best_cnt = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (task_present[i] && task_run[i] == ST_RUN && int'(task_count[i]) > best_cnt) begin
        best_cnt = int'(task_count[i]);
        best = i;
      end
    end
    return best;
  endfunction

  // Wake expired sleepers, pick, recharge once if the best count is empty; 1 if nothing runs
  function automatic bit reschedule_tasks(input logic [31:0] now);
    int best;
    logic [9:0] charged;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (task_present[i] && task_run[i] == ST_SLEEP && now > task_wake[i])
        task_run[i] = ST_RUN;
    end
    best = pick_runnable();
    if (best < 0) begin
      run_slot = '0;
      return 1'b1;
    end
    if (task_count[best] == '0) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (task_present[i]) begin
          charged = {2'b00, task_count[i][8:1]} + {2'b00, task_prio[i]};
          task_count[i] = (charged > {1'b0, COUNT_MAX}) ? COUNT_MAX : charged[8:0];
        end
      end
      best = pick_runnable();
    end
    run_slot = best[3:0];
    return 1'b0;
  endfunction

  // Apply one request to the shadow table and return the status it should produce
  function automatic cpts_out_t schedule_next(input cpts_in_t req);
    cpts_out_t res;
    logic [3:0] cur;
    bit resched;
    bit idle;
    cur = run_slot;
    resched = 1'b0;
    idle = 1'b0;
    case (req.command)
      CMD_TICK: begin
        if (task_count[cur] != '0) begin
          task_count[cur] = task_count[cur] - 9'd1;
        end else begin
          resched = 1'b1;
          idle = reschedule_tasks(req.now_time);
        end
      end
      CMD_INSTALL: begin
        task_present[req.task_index] = 1'b1;
        task_run[req.task_index] = ST_RUN;
        task_count[req.task_index] = req.initial_count;
        task_prio[req.task_index] = req.priority_req;
      end
      CMD_REMOVE: begin
        task_present[req.task_index] = 1'b0;
        task_run[req.task_index] = ST_RUN;
        task_count[req.task_index] = '0;
        task_prio[req.task_index] = '0;
        task_wake[req.task_index] = '0;
      end
      CMD_SLEEP: begin
        task_run[cur] = ST_SLEEP;
        task_wake[cur] = req.wake_time;
        resched = 1'b1;
        idle = reschedule_tasks(req.now_time);
      end
      CMD_BLOCK: begin
        task_run[cur] = ST_BLOCK;
        resched = 1'b1;
        idle = reschedule_tasks(req.now_time);
      end
      CMD_WAKE: begin
        if (task_present[req.task_index] &&
            (task_run[req.task_index] == ST_SLEEP || task_run[req.task_index] == ST_BLOCK))
          task_run[req.task_index] = ST_RUN;
      end
      default: begin
      end
    endcase
    if (resched) resched_seen++;
    if (idle) idle_seen++;
    res.current_task = run_slot;
    res.switched = resched;
    res.none_runnable = idle;
    res.current_count = task_count[run_slot];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    cpts_out_t want;
    if (!rst_n) begin
      // Clear the shadow table while reset is held
      for (int i = 0; i < NUM_SLOTS; i++) begin
        task_present[i] = 1'b0;
        task_run[i] = ST_RUN;
        task_count[i] = '0;
        task_prio[i] = '0;
        task_wake[i] = '0;
      end
      run_slot = '0;
      status_q.delete();
    end else begin
      // Compare a delivered status against the oldest prediction
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          report_mismatch("status with no request pending", 32'(out_data), '0);
        end else begin
          want = status_q.pop_front();
          if (out_data.current_task !== want.current_task)
            report_mismatch("current_task", 32'(out_data.current_task),
                            32'(want.current_task));
          if (out_data.switched !== want.switched)
            report_mismatch("switched", 32'(out_data.switched), 32'(want.switched));
          if (out_data.none_runnable !== want.none_runnable)
            report_mismatch("none_runnable", 32'(out_data.none_runnable),
                            32'(want.none_runnable));
          if (out_data.current_count !== want.current_count)
            report_mismatch("current_count", 32'(out_data.current_count),
                            32'(want.current_count));
          checked++;
        end
      end
      // Predict the status of an accepted request
      if (in_valid && !in_stall)
        status_q.push_back(schedule_next(in_data));
    end
    pending = status_q.size();
  end

endmodule

[verif/tb_top.sv]
// Testbench top for the task scheduler: clock, reset, request stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module tb_top;
  import cpts_pkg::*;

  // Command codes the block treats as no-ops
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int N_RANDOM        = 530;
  localparam int NARROW_ITEMS    = 250;
  localparam int CALM_TAIL       = 80;
  localparam int PAUSE_AT        = 350;
  localparam int HOLD_OFF_AT     = 170;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 60;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  cpts_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  cpts_out_t out_data;

  int fail_count;
  int pending;
  int checked;
  int resched_seen;
  int idle_seen;

  int          sent = 0;
  bit          calm = 1'b0;
  logic [31:0] sched_clock;

  counter_priority_task_scheduler u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  cpts_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .resched_seen(resched_seen),
    .idle_seen   (idle_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic cpts_in_t make_req(input logic [2:0] cmd, input logic [3:0] idx,
                                        input logic [7:0] prio, input logic [8:0] cnt,
                                        input logic [31:0] wake, input logic [31:0] now);
    cpts_in_t r;
    r.command = cmd;
    r.task_index = idx;
    r.priority_req = prio;
    r.initial_count = cnt;
    r.wake_time = wake;
    r.now_time = now;
    return r;
  endfunction

  // Mostly small counts and priorities so slices run out and recharges happen
  function automatic cpts_in_t random_request(input int idx_hi, input logic [31:0] now);
    cpts_in_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.command = (pick < 42) ? CMD_TICK :
                (pick < 57) ? CMD_INSTALL :
                (pick < 63) ? CMD_REMOVE :
                (pick < 73) ? CMD_SLEEP :
                (pick < 80) ? CMD_BLOCK :
                (pick < 95) ? CMD_WAKE :
                (pick < 97) ? CMD_SPARE_6 : CMD_SPARE_7;
    r.task_index = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(0, idx_hi));
    pick = $urandom_range(0, 9);
    r.priority_req = (pick < 6) ? 8'($urandom_range(0, 4)) :
                     (pick < 9) ? 8'($urandom) : 8'hFF;
    pick = $urandom_range(0, 9);
    r.initial_count = (pick < 7) ? 9'($urandom_range(0, 6)) :
                      (pick < 9) ? 9'($urandom_range(0, 63)) :
                      ($urandom_range(0, 1) == 1) ? COUNT_MAX : 9'($urandom);
    pick = $urandom_range(0, 19);
    r.wake_time = (pick < 17) ? now + 32'($urandom_range(0, 20)) :
                  (pick < 18) ? 32'($urandom) :
                  (pick < 19) ? 32'h0 : 32'hFFFF_FFFF;
    pick = $urandom_range(0, 49);
    r.now_time = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : now;
    return r;
  endfunction

  // Offer one request and hold it until accepted, then maybe idle a while
  task automatic send_request(input cpts_in_t req);
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off, then free-running
  initial begin
    bit held_off;
    held_off = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!held_off && sent >= HOLD_OFF_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Sender and verdict
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, spare codes, recharge, sleep, block, wake, removal of the runner
    send_request(make_req(CMD_TICK, 4'd0, 8'd0, 9'd0, 32'd0, 32'd0));
    send_request(make_req(CMD_SPARE_6, 4'hF, 8'hFF, 9'h1FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(CMD_SPARE_7, 4'hF, 8'hFF, 9'h1FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(CMD_INSTALL, 4'd0, 8'd0, 9'd0, 32'd0, 32'd1));
    send_request(make_req(CMD_TICK, 4'd0, 8'd0, 9'd0, 32'd0, 32'd1));
    send_request(make_req(CMD_INSTALL, 4'd15, 8'hFF, COUNT_MAX, 32'd0, 32'd2));
    send_request(make_req(CMD_TICK, 4'd0, 8'd0, 9'd0, 32'd0, 32'd2));
    send_request(make_req(CMD_TICK, 4'd0, 8'd0, 9'd0, 32'd0, 32'd3));
    send_request(make_req(CMD_INSTALL, 4'd3, 8'd2, 9'd0, 32'd0, 32'd4));
    send_request(make_req(CMD_SLEEP, 4'd0, 8'd0, 9'd0, 32'd100, 32'd50));
    send_request(make_req(CMD_BLOCK, 4'd0, 8'd0, 9'd0, 32'd0, 32'd50));
    send_request(make_req(CMD_WAKE, 4'd3, 8'd0, 9'd0, 32'd0, 32'd50));
    send_request(make_req(CMD_WAKE, 4'd7, 8'd0, 9'd0, 32'd0, 32'd50));
    send_request(make_req(CMD_WAKE, 4'd0, 8'd0, 9'd0, 32'd0, 32'd50));
    send_request(make_req(CMD_TICK, 4'd0, 8'd0, 9'd0, 32'd0, 32'd101));
    send_request(make_req(CMD_REMOVE, 4'd15, 8'd0, 9'd0, 32'd0, 32'd101));
    send_request(make_req(CMD_TICK, 4'd0, 8'd0, 9'd0, 32'd0, 32'd102));
    send_request(make_req(CMD_SLEEP, 4'd0, 8'd0, 9'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(CMD_BLOCK, 4'd0, 8'd0, 9'd0, 32'd0, 32'hFFFF_FFFF));
    send_request(make_req(CMD_TICK, 4'd0, 8'd0, 9'd0, 32'd0, 32'hFFFF_FFFF));
    send_request(make_req(CMD_WAKE, 4'd0, 8'd0, 9'd0, 32'd0, 32'd0));
    send_request(make_req(CMD_WAKE, 4'd3, 8'd0, 9'd0, 32'd0, 32'd0));
    send_request(make_req(CMD_INSTALL, 4'd9, 8'hAA, 9'h0AA, 32'h5555_5555, 32'hAAAA_AAAA));
    send_request(make_req(CMD_REMOVE, 4'd0, 8'd0, 9'd0, 32'd0, 32'd0));
    send_request(make_req(CMD_TICK, 4'd0, 8'd0, 9'd0, 32'd0, 32'd200));

    // Random: a few slots first so the table runs dry often, then the whole table
    sched_clock = 32'd200;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - CALM_TAIL) calm = 1'b1;
      if (n == PAUSE_AT) begin
        // Hold requests back until every status is in
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      sched_clock = sched_clock + 32'($urandom_range(0, 3));
      if ($urandom_range(0, 19) == 0) sched_clock = $urandom;
      send_request(random_request((n < NARROW_ITEMS) ? 3 : 15, sched_clock));
    end

    // Drain and give the verdict
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d requests, %0d statuses compared.", sent, checked);
    $display("Predicted %0d reschedules, %0d with no runnable task.", resched_seen, idle_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
